### rtl/core/chb_pkg.sv
// ----------------------------------------------------------------------------
// chb_pkg
// Shared types and constants of the clamped histogram accumulator.
// ----------------------------------------------------------------------------
package chb_pkg;

	localparam int DEF_BINS        = 1024;
	localparam int DEF_COUNT_WIDTH = 32;

	localparam int SAMPLE_W  = 32;
	localparam int CFG_W     = 32;
	localparam int CFG_IDX_W = 2;
	localparam int BINS_W    = 11;
	localparam int OUT_BIN_W = 10;
	localparam int OUT_CNT_W = 32;
	localparam int PROD_W    = 64;
	localparam int FRAC_W    = 16;
	localparam int BINVAL_W  = PROD_W - FRAC_W;

	localparam logic [BINS_W-1:0] BINS_IN_USE_RESET = 11'd1024;

	typedef enum logic [1:0] {
		OP_ADD   = 2'd0,
		OP_READ  = 2'd1,
		OP_CLEAR = 2'd2,
		OP_NONE  = 2'd3
	} opcode_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_RANGE_MIN = 2'd0,
		REG_RANGE_MAX = 2'd1,
		REG_BINS      = 2'd2,
		REG_SCALE     = 2'd3
	} cfg_reg_t;

	typedef enum logic [1:0] {
		FLAG_IN    = 2'd0,
		FLAG_BELOW = 2'd1,
		FLAG_ABOVE = 2'd2
	} range_flag_t;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_MUL,
		ST_LOOK,
		ST_UPDATE
	} state_t;

	// Stage enables from the sequencer to the binning datapath.
	typedef struct packed {
		logic offset_en;
		logic mul_en;
	} binmap_ctrl_t;

endpackage

### rtl/core/chb_binmap.sv
// ----------------------------------------------------------------------------
// chb_binmap
// Clamps a sample into the configured range and scales its offset into a bin.
// ----------------------------------------------------------------------------
module chb_binmap import chb_pkg::*; (
	input  logic                       clk,
	input  binmap_ctrl_t               ctrl,
	input  logic signed [SAMPLE_W-1:0] sample,
	input  logic signed [SAMPLE_W-1:0] range_minimum,
	input  logic signed [SAMPLE_W-1:0] range_maximum,
	input  logic        [CFG_W-1:0]    bin_scale,
	output logic        [1:0]          range_flag,
	output logic        [BINVAL_W-1:0] bin_value
);

	logic                       below;
	logic                       above;
	logic signed [SAMPLE_W-1:0] clamped;
	logic signed [SAMPLE_W:0]   diff;
	logic [SAMPLE_W-1:0]        offset;
	logic [SAMPLE_W-1:0]        offset_s1;
	logic [1:0]                 flag_s1;
	logic [PROD_W-1:0]          product_s2;

	always_comb begin
		below   = sample < range_minimum;
		above   = !below && (sample > range_maximum);
		clamped = below ? range_minimum : (above ? range_maximum : sample);
		diff    = {clamped[SAMPLE_W-1], clamped} - {range_minimum[SAMPLE_W-1], range_minimum};
		// With the minimum above the maximum the offset can go negative; it stops at zero.
		offset  = diff[SAMPLE_W] ? '0 : diff[SAMPLE_W-1:0];
	end

	always_ff @(posedge clk) begin
		if (ctrl.offset_en) begin
			offset_s1 <= offset;
			flag_s1   <= below ? FLAG_BELOW : (above ? FLAG_ABOVE : FLAG_IN);
		end
		if (ctrl.mul_en) begin
			product_s2 <= offset_s1 * bin_scale;
		end
	end

	assign range_flag = flag_s1;
	assign bin_value  = product_s2[PROD_W-1:FRAC_W];

endmodule

### rtl/core/clamped_histogram_accumulator_top.sv
// ----------------------------------------------------------------------------
// clamped_histogram_accumulator_top
// One-dimensional histogram engine over a store of saturating bin counters.
// ----------------------------------------------------------------------------
// Commands enter on start/opcode/sample/read_index and are taken at a clock
// edge where start is high and busy is low. Each command yields exactly one
// result on bin/count/range_flag/dropped, valid for the single cycle in which
// done is high; the receiver has no way to stall it.
// An add passes through the multiply by the scale, the lookup of the counter
// in the store, the write-back and the output register. A read skips the
// multiply, an unused opcode goes straight to the output register, and a
// clear zeroes the store one entry per cycle through its single write port.
// busy drops in the cycle the result is shown, so the next command may be
// transferred in that same cycle.
// After reset the block sweeps the store to zero with busy high;
// configuration writes are taken at any time, including during the sweep.
// Registers: 0 range minimum, 1 range maximum, 2 bins in use, 3 Q16.16 scale.
// ----------------------------------------------------------------------------
module clamped_histogram_accumulator_top import chb_pkg::*; #(
	parameter int BINS        = DEF_BINS,
	parameter int COUNT_WIDTH = DEF_COUNT_WIDTH
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	output logic                       busy,
	input  logic [1:0]                 opcode,
	input  logic signed [SAMPLE_W-1:0] sample,
	input  logic [OUT_BIN_W-1:0]       read_index,
	output logic                       done,
	output logic [OUT_BIN_W-1:0]       bin,
	output logic [OUT_CNT_W-1:0]       count,
	output logic [1:0]                 range_flag,
	output logic                       dropped,
	input  logic                       cfg_we,
	input  logic [CFG_IDX_W-1:0]       cfg_index,
	input  logic [CFG_W-1:0]           cfg_data
);

	localparam int AW = $clog2(BINS);
	localparam logic [BINVAL_W-1:0] BINS_LIMIT = BINVAL_W'(BINS);
	localparam logic [AW-1:0]       LAST_ADDR  = AW'(BINS - 1);

	// Configuration registers
	logic signed [SAMPLE_W-1:0] range_min_q;
	logic signed [SAMPLE_W-1:0] range_max_q;
	logic [BINS_W-1:0]          bins_in_use_q;
	logic [CFG_W-1:0]           bin_scale_q;

	// Sequencer
	state_t                 state_q, state_d;
	logic [1:0]             op_q;
	logic [OUT_BIN_W-1:0]   index_q;
	logic [AW-1:0]          clr_addr_q;
	logic                   clr_report_q;
	logic                   accept;
	binmap_ctrl_t           bm_ctrl;
	logic                   rd_en;
	logic                   look_en;
	logic                   emit_update;
	logic                   emit_clear;

	// Lookup stage
	logic [AW-1:0]          addr_q;
	logic [OUT_BIN_W-1:0]   bin_q;
	logic                   drop_q;
	logic                   add_q;
	logic [AW-1:0]          look_addr;
	logic [OUT_BIN_W-1:0]   look_bin;
	logic                   look_drop;
	logic [BINVAL_W-1:0]    limit;
	logic [BINVAL_W-1:0]    bins_ext;
	logic [AW+OUT_BIN_W-1:0] idx_ext;

	// Store and update
	logic [COUNT_WIDTH-1:0] mem_q [BINS];
	logic [COUNT_WIDTH-1:0] rdata_q;
	logic [COUNT_WIDTH-1:0] new_count;
	logic [COUNT_WIDTH-1:0] res_count;
	logic [COUNT_WIDTH+OUT_CNT_W-1:0] count_ext;
	logic                   wr_en;
	logic [AW-1:0]          wr_addr;
	logic [COUNT_WIDTH-1:0] wr_data;

	// Binning datapath
	logic [1:0]             bm_flag;
	logic [BINVAL_W-1:0]    bm_bin_value;

	// Output registers
	logic                   done_q;
	logic [OUT_BIN_W-1:0]   res_bin_q;
	logic [OUT_CNT_W-1:0]   res_count_q;
	logic [1:0]             res_flag_q;
	logic                   res_drop_q;

	chb_binmap u_binmap (
		.clk           (clk),
		.ctrl          (bm_ctrl),
		.sample        (sample),
		.range_minimum (range_min_q),
		.range_maximum (range_max_q),
		.bin_scale     (bin_scale_q),
		.range_flag    (bm_flag),
		.bin_value     (bm_bin_value)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			range_min_q   <= '0;
			range_max_q   <= '0;
			bins_in_use_q <= BINS_IN_USE_RESET;
			bin_scale_q   <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_RANGE_MIN: range_min_q   <= cfg_data;
				REG_RANGE_MAX: range_max_q   <= cfg_data;
				REG_BINS:      bins_in_use_q <= cfg_data[BINS_W-1:0];
				REG_SCALE:     bin_scale_q   <= cfg_data;
				default:       ;
			endcase
		end
	end

	assign busy   = (state_q != ST_IDLE);
	assign accept = start && !busy;

	always_comb begin
		state_d          = state_q;
		bm_ctrl.offset_en = accept;
		bm_ctrl.mul_en    = 1'b0;
		rd_en            = 1'b0;
		look_en          = 1'b0;
		emit_update      = 1'b0;
		emit_clear       = 1'b0;
		case (state_q)
			ST_CLEAR: begin
				if (clr_addr_q == LAST_ADDR) begin
					state_d    = ST_IDLE;
					emit_clear = clr_report_q;
				end
			end
			ST_IDLE: begin
				if (accept) begin
					case (opcode)
						OP_ADD:   state_d = ST_MUL;
						OP_READ:  state_d = ST_LOOK;
						OP_CLEAR: state_d = ST_CLEAR;
						default:  state_d = ST_UPDATE;
					endcase
				end
			end
			ST_MUL: begin
				bm_ctrl.mul_en = 1'b1;
				state_d        = ST_LOOK;
			end
			ST_LOOK: begin
				look_en = 1'b1;
				rd_en   = !look_drop;
				state_d = ST_UPDATE;
			end
			ST_UPDATE: begin
				emit_update = 1'b1;
				state_d     = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_CLEAR;
			clr_addr_q   <= '0;
			clr_report_q <= 1'b0;
			op_q         <= OP_NONE;
		end else begin
			state_q <= state_d;
			if (state_q == ST_CLEAR) begin
				clr_addr_q <= clr_addr_q + 1'b1;
			end else begin
				clr_addr_q <= '0;
			end
			if (accept) begin
				op_q         <= opcode;
				clr_report_q <= (opcode == OP_CLEAR);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			index_q <= read_index;
		end
	end

	// Lookup: bin limit checks and the store address for an add or a read.
	always_comb begin
		bins_ext  = BINVAL_W'(bins_in_use_q);
		limit     = (bins_ext < BINS_LIMIT) ? bins_ext : BINS_LIMIT;
		idx_ext   = {{AW{1'b0}}, index_q};
		if (op_q == OP_ADD) begin
			look_drop = (bm_bin_value >= limit);
			look_addr = bm_bin_value[AW-1:0];
			look_bin  = bm_bin_value[OUT_BIN_W-1:0];
		end else begin
			look_drop = (BINVAL_W'(index_q) >= BINS_LIMIT);
			look_addr = idx_ext[AW-1:0];
			look_bin  = index_q;
		end
	end

	always_ff @(posedge clk) begin
		if (look_en) begin
			addr_q <= look_addr;
			bin_q  <= look_bin;
			drop_q <= look_drop;
			add_q  <= (op_q == OP_ADD);
		end
	end

	// Items are taken one at a time, so a write-back always lands before the
	// next lookup and no forwarding is needed.
	always_comb begin
		new_count = (rdata_q == {COUNT_WIDTH{1'b1}}) ? rdata_q : rdata_q + 1'b1;
		res_count = add_q ? new_count : rdata_q;
		count_ext = {{OUT_CNT_W{1'b0}}, res_count};
		wr_en     = (state_q == ST_CLEAR) ||
		            (emit_update && (op_q == OP_ADD) && !drop_q);
		wr_addr   = (state_q == ST_CLEAR) ? clr_addr_q : addr_q;
		wr_data   = (state_q == ST_CLEAR) ? '0 : new_count;
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rdata_q <= mem_q[look_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= emit_update || emit_clear;
		end
	end

	always_ff @(posedge clk) begin
		if (emit_update || emit_clear) begin
			res_bin_q   <= '0;
			res_count_q <= '0;
			res_flag_q  <= FLAG_IN;
			res_drop_q  <= 1'b0;
			if (emit_update && (op_q == OP_ADD)) begin
				res_flag_q  <= bm_flag;
				res_drop_q  <= drop_q;
				if (!drop_q) begin
					res_bin_q   <= bin_q;
					res_count_q <= count_ext[OUT_CNT_W-1:0];
				end
			end else if (emit_update && (op_q == OP_READ)) begin
				res_bin_q  <= bin_q;
				res_drop_q <= drop_q;
				if (!drop_q) begin
					res_count_q <= count_ext[OUT_CNT_W-1:0];
				end
			end
		end
	end

	assign done       = done_q;
	assign bin        = res_bin_q;
	assign count      = res_count_q;
	assign range_flag = res_flag_q;
	assign dropped    = res_drop_q;

endmodule

### rtl/core/chb_checker.sv
// ----------------------------------------------------------------------------
// chb_checker
// Port-level checks on the histogram accumulator's command and result timing.
// ----------------------------------------------------------------------------
module chb_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        start,
	input logic        busy,
	input logic        done,
	input logic [31:0] count,
	input logic [1:0]  range_flag,
	input logic        dropped
);

	// Every command transfer raises busy in the cycle after it.
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy)
		else $error("busy not raised after a command transfer");

	// A result appears only once the block is free again.
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("result shown while still busy");

	// One command at a time, so results never come in adjacent cycles.
	a_done_single: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("results in two consecutive cycles");

	a_drop_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && dropped) |-> (count == 32'd0))
		else $error("dropped result carries a non-zero count");

	a_flag_code: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (range_flag != 2'd3))
		else $error("range flag carries an unused code");

endmodule

bind clamped_histogram_accumulator_top chb_checker u_chb_checker (.*);
